FILE: rtl/wlf_pkg.sv
// Shared types, constants and codes for the weighted line fit block.
// No dependencies; imported by every RTL file except the two interfaces.
`timescale 1ns / 1ps

package wlf_pkg;

  localparam int WLF_MAX_POINTS = 4096;

  localparam int SW_W  = 29;
  localparam int SX_W  = 45;
  localparam int SXX_W = 60;
  localparam int SXY_W = 61;

  localparam int WIDE_W  = 128;
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 48;
  localparam int DIV_N   = WIDE_W;
  localparam int ROOT_W  = 64;
  localparam int ROOT_N  = ROOT_W / 2;

  typedef logic [WIDE_W-1:0] wide_t;

  typedef enum logic [3:0] {
    OP_T,
    OP_D,
    OP_A1,
    OP_A2,
    OP_B1,
    OP_B2,
    OP_DS,
    OP_DI,
    OP_DSS,
    OP_QSS,
    OP_DIS,
    OP_QIS
  } op_t;

  typedef enum logic [1:0] {
    FIT_OK    = 2'd0,
    FIT_DEGEN = 2'd1,
    FIT_MANY  = 2'd2
  } fit_status_t;

  typedef struct packed {
    logic        take;
    logic        go;
    op_t         op;
    logic        load;
    fit_status_t status;
  } wlf_cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic overflow;
    logic done;
    logic degen;
  } wlf_stat_t;

  typedef struct packed {
    logic        [SW_W-1:0]  sw;
    logic signed [SX_W-1:0]  sx;
    logic signed [SX_W-1:0]  sy;
    logic        [SXX_W-1:0] sxx;
    logic signed [SXY_W-1:0] sxy;
  } sums_t;

endpackage

FILE: rtl/wlf_point_if.sv
// Input channel: one weighted point per item, valid/ready handshake.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps

interface wlf_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic        [15:0] weight;
  logic               last_point;

  modport source (output valid, x_value, y_value, weight, last_point, input ready);
  modport sink   (input valid, x_value, y_value, weight, last_point, output ready);
endinterface

FILE: rtl/wlf_fit_if.sv
// Output channel: one fit result per item, valid/ready handshake.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps

interface wlf_fit_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] slope;
  logic signed [31:0] intercept;
  logic        [31:0] slope_sigma;
  logic        [31:0] intercept_sigma;
  logic        [1:0]  fit_status;

  modport source (output valid, slope, intercept, slope_sigma, intercept_sigma, fit_status,
                  input ready);
  modport sink   (input valid, slope, intercept, slope_sigma, intercept_sigma, fit_status,
                  output ready);
endinterface

FILE: rtl/wlf_ctrl.sv
// Sequencer for the line fit: accept, drain, operation steps, result handoff.
// Depends on wlf_pkg for command, status and operation codes.
`timescale 1ns / 1ps

module wlf_ctrl import wlf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  wlf_stat_t stat,
  output wlf_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_ACC   = 6'b000001,
    S_DRAIN = 6'b000010,
    S_RUN   = 6'b000100,
    S_CHK0  = 6'b001000,
    S_CHK1  = 6'b010000,
    S_LOAD  = 6'b100000
  } state_t;

  state_t      state, state_next;
  op_t         op, op_next;
  logic        launched, launched_next;
  fit_status_t status, status_next;
  logic        out_valid_next;

  assign in_ready = (state == S_ACC);

  always_comb begin
    state_next     = state;
    op_next        = op;
    launched_next  = launched;
    status_next    = status;
    out_valid_next = out_valid && !out_ready;
    cmd.take       = in_valid && in_ready;
    cmd.go         = 1'b0;
    cmd.op         = op;
    cmd.load       = 1'b0;
    cmd.status     = status;
    case (state)
      S_ACC: begin
        if (in_valid && in_ready && in_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat.pipe_empty) begin
          if (stat.overflow) begin
            status_next = FIT_MANY;
            state_next  = S_LOAD;
          end else begin
            op_next       = OP_T;
            launched_next = 1'b0;
            state_next    = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (!launched) begin
          cmd.go        = 1'b1;
          launched_next = 1'b1;
        end else if (stat.done) begin
          launched_next = 1'b0;
          if (op == OP_D) begin
            state_next = S_CHK0;
          end else if (op == OP_QIS) begin
            status_next = FIT_OK;
            state_next  = S_LOAD;
          end else begin
            op_next = op_t'(op + 4'd1);
          end
        end
      end
      S_CHK0: begin
        state_next = S_CHK1;
      end
      S_CHK1: begin
        if (stat.degen) begin
          status_next = FIT_DEGEN;
          state_next  = S_LOAD;
        end else begin
          op_next    = OP_A1;
          state_next = S_RUN;
        end
      end
      S_LOAD: begin
        if (!out_valid || out_ready) begin
          cmd.load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACC;
      op        <= OP_T;
      launched  <= 1'b0;
      status    <= FIT_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      launched  <= launched_next;
      status    <= status_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/wlf_accum.sv
// Point accumulator: two multiply stages feeding the five weighted sums.
// Depends on wlf_pkg; driven by wlf_ctrl commands.
`timescale 1ns / 1ps

module wlf_accum import wlf_pkg::*; #(
  parameter int MAX_POINTS = WLF_MAX_POINTS
) (
  input  logic               clk,
  input  logic               rst,
  input  wlf_cmd_t           cmd,
  input  logic signed [15:0] x_value,
  input  logic signed [15:0] y_value,
  input  logic        [15:0] weight,
  output sums_t              sums,
  output logic               pipe_empty,
  output logic               overflow
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  logic [CNT_W-1:0] count;
  logic             add_ok;

  logic signed [32:0] wx_c, wy_c;
  logic signed [31:0] xx_c;
  logic        [46:0] xxw_c;
  logic signed [48:0] wxy_c;

  logic               v1, v2;
  logic signed [32:0] wx1, wy1, wx2, wy2;
  logic        [30:0] xx1;
  logic        [15:0] w1, w2;
  logic signed [15:0] y1;
  logic        [46:0] xxw2;
  logic signed [48:0] wxy2;

  assign add_ok = cmd.take && (count != CNT_MAX);

  assign wx_c = $signed({17'b0, weight}) * $signed({{17{x_value[15]}}, x_value});
  assign wy_c = $signed({17'b0, weight}) * $signed({{17{y_value[15]}}, y_value});
  assign xx_c = $signed({{16{x_value[15]}}, x_value}) * $signed({{16{x_value[15]}}, x_value});
  assign xxw_c = {16'b0, xx1} * {31'b0, w1};
  assign wxy_c = $signed({{16{wx1[32]}}, wx1}) * $signed({{33{y1[15]}}, y1});

  assign pipe_empty = !v1 && !v2;

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (cmd.take) begin
      if (count == CNT_MAX) overflow <= 1'b1;
      else count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= add_ok;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    wx1  <= wx_c;
    wy1  <= wy_c;
    xx1  <= xx_c[30:0];
    w1   <= weight;
    y1   <= y_value;
    wx2  <= wx1;
    wy2  <= wy1;
    w2   <= w1;
    xxw2 <= xxw_c;
    wxy2 <= wxy_c;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      sums <= '0;
    end else if (v2) begin
      sums.sw  <= sums.sw + {13'b0, w2};
      sums.sx  <= sums.sx + {{12{wx2[32]}}, wx2};
      sums.sy  <= sums.sy + {{12{wy2[32]}}, wy2};
      sums.sxx <= sums.sxx + {13'b0, xxw2};
      sums.sxy <= sums.sxy + {{12{wxy2[48]}}, wxy2};
    end
  end

endmodule

FILE: rtl/wlf_solver.sv
// Fit solver: serial multiplier, restoring divider and square root unit,
// working registers and the result register. Depends on wlf_pkg.
`timescale 1ns / 1ps

module wlf_solver import wlf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  wlf_cmd_t           cmd,
  input  sums_t              sums,
  output logic               done,
  output logic               degen,
  output logic signed [31:0] slope,
  output logic signed [31:0] intercept,
  output logic        [31:0] slope_sigma,
  output logic        [31:0] intercept_sigma,
  output logic        [1:0]  fit_status
);

  localparam int MC_W = $clog2(MUL_B_W);
  localparam int DC_W = $clog2(DIV_N);
  localparam int RC_W = $clog2(ROOT_N);

  logic is_mul, is_div, is_root;

  wide_t t, d, an, bn, d1016, d8;
  logic [ROOT_W-1:0] sq_in;
  logic signed [31:0] slope_w, icpt_w;
  logic        [31:0] ss_w, is_w;

  logic signed [MUL_A_W-1:0] sa, sb;
  logic        [MUL_A_W-1:0] mag_a, mag_b;
  logic              mul_run, mul_fix, mul_neg;
  logic [MC_W-1:0]   mul_cnt;
  wide_t             mul_a, mul_acc;
  logic [MUL_B_W-1:0] mul_b;

  wide_t             num, num_mag, div_n, div_r, div_q, div_rsh;
  logic              div_run, div_neg, div_ge;
  logic [DC_W-1:0]   div_cnt;

  logic              sq_run;
  logic [RC_W-1:0]   sq_cnt;
  logic [ROOT_W-1:0] sq_v, sq_res, sq_bit, sq_sum;

  always_comb begin
    is_mul  = cmd.op inside {OP_T, OP_D, OP_A1, OP_A2, OP_B1, OP_B2};
    is_div  = cmd.op inside {OP_DS, OP_DI, OP_DSS, OP_DIS};
    is_root = cmd.op inside {OP_QSS, OP_QIS};
  end

  always_comb begin
    case (cmd.op)
      OP_T: begin
        sa = {4'b0, sums.sxx};
        sb = {35'b0, sums.sw};
      end
      OP_D: begin
        sa = {{19{sums.sx[44]}}, sums.sx};
        sb = {{19{sums.sx[44]}}, sums.sx};
      end
      OP_A1: begin
        sa = {{3{sums.sxy[60]}}, sums.sxy};
        sb = {35'b0, sums.sw};
      end
      OP_A2: begin
        sa = {{19{sums.sy[44]}}, sums.sy};
        sb = {{19{sums.sx[44]}}, sums.sx};
      end
      OP_B1: begin
        sa = {4'b0, sums.sxx};
        sb = {{19{sums.sy[44]}}, sums.sy};
      end
      OP_B2: begin
        sa = {{3{sums.sxy[60]}}, sums.sxy};
        sb = {{19{sums.sx[44]}}, sums.sx};
      end
      default: begin
        sa = '0;
        sb = '0;
      end
    endcase
    mag_a = sa[MUL_A_W-1] ? (~sa + MUL_A_W'(1)) : sa;
    mag_b = sb[MUL_A_W-1] ? (~sb + MUL_A_W'(1)) : sb;
  end

  always_comb begin
    case (cmd.op)
      OP_DS:   num = {an[WIDE_W-17:0], 16'b0};
      OP_DI:   num = {bn[WIDE_W-9:0], 8'b0};
      OP_DSS:  num = {35'b0, sums.sw, 64'b0};
      OP_DIS:  num = {20'b0, sums.sxx, 48'b0};
      default: num = '0;
    endcase
    num_mag = num[WIDE_W-1] ? (~num + WIDE_W'(1)) : num;
  end

  assign div_rsh = {div_r[WIDE_W-2:0], div_n[WIDE_W-1]};
  assign div_ge  = (div_rsh >= d);
  assign sq_sum  = sq_res + sq_bit;

  assign d8    = {d[WIDE_W-4:0], 3'b0};
  assign degen = d[WIDE_W-1] || (d == '0) || ((d1016 - d8) < t);

  function automatic logic [31:0] sat_quot(input logic neg, input wide_t q);
    if (neg) begin
      if (q[WIDE_W-1:32] != '0 || q[31:0] > 32'h8000_0000) return 32'h8000_0000;
      return ~q[31:0] + 32'd1;
    end
    if (q[WIDE_W-1:31] != '0) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_run <= 1'b0;
      mul_fix <= 1'b0;
      div_run <= 1'b0;
      sq_run  <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.go && is_mul) begin
        mul_run <= 1'b1;
      end else if (mul_run && mul_cnt == MC_W'(MUL_B_W - 1)) begin
        mul_run <= 1'b0;
        mul_fix <= 1'b1;
      end else if (mul_fix) begin
        mul_fix <= 1'b0;
        done    <= 1'b1;
      end
      if (cmd.go && is_div) begin
        div_run <= 1'b1;
      end else if (div_run && div_cnt == DC_W'(DIV_N - 1)) begin
        div_run <= 1'b0;
        done    <= 1'b1;
      end
      if (cmd.go && is_root) begin
        sq_run <= 1'b1;
      end else if (sq_run && sq_cnt == RC_W'(ROOT_N - 1)) begin
        sq_run <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go && is_mul) begin
      mul_a   <= {64'b0, mag_a};
      mul_b   <= mag_b[MUL_B_W-1:0];
      mul_acc <= '0;
      mul_neg <= sa[MUL_A_W-1] ^ sb[MUL_A_W-1];
      mul_cnt <= '0;
    end else if (mul_run) begin
      if (mul_b[0]) mul_acc <= mul_acc + mul_a;
      mul_a   <= {mul_a[WIDE_W-2:0], 1'b0};
      mul_b   <= {1'b0, mul_b[MUL_B_W-1:1]};
      mul_cnt <= mul_cnt + MC_W'(1);
    end else if (mul_fix && mul_neg) begin
      mul_acc <= ~mul_acc + WIDE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go && is_div) begin
      div_n   <= num_mag;
      div_r   <= '0;
      div_q   <= '0;
      div_neg <= num[WIDE_W-1];
      div_cnt <= '0;
    end else if (div_run) begin
      div_r   <= div_ge ? (div_rsh - d) : div_rsh;
      div_q   <= {div_q[WIDE_W-2:0], div_ge};
      div_n   <= {div_n[WIDE_W-2:0], 1'b0};
      div_cnt <= div_cnt + DC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go && is_root) begin
      sq_v   <= sq_in;
      sq_res <= '0;
      sq_bit <= {2'b01, {(ROOT_W - 2){1'b0}}};
      sq_cnt <= '0;
    end else if (sq_run) begin
      if (sq_v >= sq_sum) begin
        sq_v   <= sq_v - sq_sum;
        sq_res <= {1'b0, sq_res[ROOT_W-1:1]} + sq_bit;
      end else begin
        sq_res <= {1'b0, sq_res[ROOT_W-1:1]};
      end
      sq_bit <= {2'b00, sq_bit[ROOT_W-1:2]};
      sq_cnt <= sq_cnt + RC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    d1016 <= {d[WIDE_W-11:0], 10'b0} - {d[WIDE_W-5:0], 4'b0};
    if (done) begin
      case (cmd.op)
        OP_T:    t  <= mul_acc;
        OP_D:    d  <= t - mul_acc;
        OP_A1:   an <= mul_acc;
        OP_A2:   an <= an - mul_acc;
        OP_B1:   bn <= mul_acc;
        OP_B2:   bn <= bn - mul_acc;
        OP_DS:   slope_w <= sat_quot(div_neg, div_q);
        OP_DI:   icpt_w  <= sat_quot(div_neg, div_q);
        OP_DSS,
        OP_DIS:  sq_in <= (div_q[WIDE_W-1:ROOT_W] != '0) ? '1 : div_q[ROOT_W-1:0];
        OP_QSS:  ss_w <= sq_res[31:0];
        OP_QIS:  is_w <= sq_res[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fit_status <= cmd.status;
      if (cmd.status == FIT_OK) begin
        slope           <= slope_w;
        intercept       <= icpt_w;
        slope_sigma     <= ss_w;
        intercept_sigma <= is_w;
      end else begin
        slope           <= '0;
        intercept       <= '0;
        slope_sigma     <= '0;
        intercept_sigma <= '0;
      end
    end
  end

endmodule

FILE: rtl/weighted_line_fit_top.sv
// Weighted least-squares line fit, top level: sequencer, accumulator, solver.
// Depends on wlf_pkg, wlf_point_if, wlf_fit_if, wlf_ctrl, wlf_accum, wlf_solver.
//
// Points stream in at one item per cycle while the block is accepting, and are
// summed exactly through a two-stage multiply pipeline. The item marked last
// closes the set: the fit then runs on a shared bit-serial multiplier (six
// products), a restoring divider (four quotients) and a digit square root (two
// roots), during which no point is taken. Degenerate sets stop after the first
// two products and too-many-point sets skip the fit. A pending result may wait
// on the output while the next set is being summed.
`timescale 1ns / 1ps

module weighted_line_fit_top import wlf_pkg::*; #(
  parameter int MAX_POINTS = WLF_MAX_POINTS
) (
  input logic        clk,
  input logic        rst,
  wlf_point_if.sink  points,
  wlf_fit_if.source  fit
);

  wlf_cmd_t  cmd;
  wlf_stat_t stat;
  sums_t     sums;
  logic      pipe_empty, overflow, done, degen;

  assign stat.pipe_empty = pipe_empty;
  assign stat.overflow   = overflow;
  assign stat.done       = done;
  assign stat.degen      = degen;

  wlf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_last   (points.last_point),
    .in_ready  (points.ready),
    .out_valid (fit.valid),
    .out_ready (fit.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wlf_accum #(.MAX_POINTS(MAX_POINTS)) u_accum (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .x_value    (points.x_value),
    .y_value    (points.y_value),
    .weight     (points.weight),
    .sums       (sums),
    .pipe_empty (pipe_empty),
    .overflow   (overflow)
  );

  wlf_solver u_solver (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sums            (sums),
    .done            (done),
    .degen           (degen),
    .slope           (fit.slope),
    .intercept       (fit.intercept),
    .slope_sigma     (fit.slope_sigma),
    .intercept_sigma (fit.intercept_sigma),
    .fit_status      (fit.fit_status)
  );

endmodule

FILE: rtl/wlf_checker.sv
// Port-level checks for the line fit top level, attached by bind.
// Depends on wlf_pkg and weighted_line_fit_top.
`timescale 1ns / 1ps

module wlf_checker import wlf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        pv,
  input logic        pr,
  input logic        plast,
  input logic        fv,
  input logic        fr,
  input logic [1:0]  fst,
  input logic [31:0] slp,
  input logic [31:0] icp,
  input logic [31:0] ssg,
  input logic [31:0] isg
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst) fv && !fr |=> fv)
    else $error("result dropped before taken");

  a_last_stall: assert property (@(posedge clk) disable iff (rst) pv && pr && plast |=> !pr)
    else $error("point taken right after last point");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
      fv && fst != FIT_OK |-> slp == '0 && icp == '0 && ssg == '0 && isg == '0)
    else $error("failed fit with nonzero fields");

endmodule

bind weighted_line_fit_top wlf_checker u_wlf_checker (
  .clk   (clk),
  .rst   (rst),
  .pv    (points.valid),
  .pr    (points.ready),
  .plast (points.last_point),
  .fv    (fit.valid),
  .fr    (fit.ready),
  .fst   (fit.fit_status),
  .slp   (fit.slope),
  .icp   (fit.intercept),
  .ssg   (fit.slope_sigma),
  .isg   (fit.intercept_sigma)
);
